// ===== rtl/double_ended_queue_with_search_assert.svh =====
// ----------------------------------------------------------------------------
// Double-ended queue with search: assertion macros
// Shared property shorthands, clocked on clk and disabled during rst.
// ----------------------------------------------------------------------------
`ifndef DOUBLE_ENDED_QUEUE_WITH_SEARCH_ASSERT_SVH
`define DOUBLE_ENDED_QUEUE_WITH_SEARCH_ASSERT_SVH

// Same-cycle implication.
`define DQS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define DQS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/dqs_pkg.sv =====
// ----------------------------------------------------------------------------
// dqs_pkg
// Sizes, request and status codes and ring helpers for the deque.
// ----------------------------------------------------------------------------
package dqs_pkg;

  localparam int CAPACITY    = 16;
  localparam int VALUE_WIDTH = 32;

  localparam int IDX_W = $clog2(CAPACITY);
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int SUM_W = CNT_W + 1;

  // fixed port widths
  localparam int ACTION_W = 3;
  localparam int DATA_W   = 32;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 5;

  typedef enum logic [ACTION_W-1:0] {
    ACT_PUSH_FRONT = 3'd0,
    ACT_PUSH_BACK  = 3'd1,
    ACT_POP_FRONT  = 3'd2,
    ACT_POP_BACK   = 3'd3,
    ACT_SEARCH     = 3'd4,
    ACT_CLEAR      = 3'd5
  } action_t;

  localparam logic [STATUS_W-1:0] STAT_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_FULL  = 2'd2;

  // (base + off) mod CAPACITY; sum stays below twice the capacity
  function automatic logic [IDX_W-1:0] ring_add(logic [IDX_W-1:0] base,
                                                logic [CNT_W-1:0] off);
    logic [SUM_W-1:0] sum;
    sum = SUM_W'(base) + SUM_W'(off);
    if (sum >= SUM_W'(CAPACITY)) begin
      sum = sum - SUM_W'(CAPACITY);
    end
    return sum[IDX_W-1:0];
  endfunction

  // sign-extend the port value, keep the stored width
  function automatic logic [VALUE_WIDTH-1:0] to_store(logic signed [DATA_W-1:0] d);
    logic signed [63:0] w;
    w = 64'(d);
    return w[VALUE_WIDTH-1:0];
  endfunction

  // stored value back to the port, zero-extended
  function automatic logic signed [DATA_W-1:0] to_out(logic [VALUE_WIDTH-1:0] v);
    logic [63:0] w;
    w = 64'(v);
    return w[DATA_W-1:0];
  endfunction

  function automatic logic [COUNT_W-1:0] to_count(logic [CNT_W-1:0] c);
    logic [63:0] w;
    w = 64'(c);
    return w[COUNT_W-1:0];
  endfunction

endpackage

// ===== rtl/double_ended_queue_with_search.sv =====
// ----------------------------------------------------------------------------
// double_ended_queue_with_search
// Bounded deque in a ring store with a front pointer, an element count and
// one shared comparator that walks the ring to search for a key.
// ----------------------------------------------------------------------------
//
//  Channel | Handshake           | Payload                          | Dir
//  --------+---------------------+----------------------------------+-----
//  request | in_valid / in_stall | action, data_in                  | in
//  result  | out_valid/out_stall | value_out, found, status, count  | out
//
//  Push, clear, unused codes and a pop of an empty deque go from S_IDLE to S_RESP;
//  other pops pass through S_POP between them, for the registered read port of the store.
//  A search of a non-empty deque walks S_SCAN, the single comparator
//  checking one stored entry per cycle, front to back, until a match or
//  the back entry; a search of an empty deque goes straight to S_RESP.
//  rst is synchronous: pointer and count go to zero, the store is not
//  cleared (entries are only read once written).
//  A result held by out_stall does not block the next request; only a
//  second result waits for the output register to free.
// ----------------------------------------------------------------------------
module double_ended_queue_with_search (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic [dqs_pkg::ACTION_W-1:0]          action,
  input  logic signed [dqs_pkg::DATA_W-1:0]     data_in,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic signed [dqs_pkg::DATA_W-1:0]     value_out,
  output logic                                  found,
  output logic [dqs_pkg::STATUS_W-1:0]          status,
  output logic [dqs_pkg::COUNT_W-1:0]           count
);

  typedef enum logic [1:0] {
    S_IDLE,   // waiting for a request
    S_POP,    // pop read data arriving from the store
    S_SCAN,   // search walk: issue read, compare previous
    S_RESP    // result ready, waiting for the output register
  } state_t;

  state_t                              state;

  // ring store: one write port, one registered read port
  logic [dqs_pkg::VALUE_WIDTH-1:0]     store [dqs_pkg::CAPACITY];
  logic [dqs_pkg::VALUE_WIDTH-1:0]     rd_data;
  logic [dqs_pkg::IDX_W-1:0]           rd_addr;
  logic [dqs_pkg::IDX_W-1:0]           wr_addr;
  logic                                wr_en;

  // queue bookkeeping
  logic [dqs_pkg::IDX_W-1:0]           front;
  logic [dqs_pkg::CNT_W-1:0]           elem_count;

  // search walk
  logic [dqs_pkg::CNT_W-1:0]           scan_idx;
  logic                                cmp_vld;   // rd_data holds a scanned entry
  logic                                cmp_last;  // ... and it is the back one
  logic [dqs_pkg::VALUE_WIDTH-1:0]     key;

  // result waiting for the output register
  logic [dqs_pkg::VALUE_WIDTH-1:0]     res_value;
  logic                                res_found;
  logic [dqs_pkg::STATUS_W-1:0]        res_status;

  logic                                accept;
  logic                                is_full;
  logic                                is_empty;
  logic                                is_push;
  logic [dqs_pkg::VALUE_WIDTH-1:0]     store_val;
  dqs_pkg::action_t                    act;

  assign in_stall  = (state != S_IDLE);
  assign accept    = in_valid && !in_stall;
  assign act       = dqs_pkg::action_t'(action);
  assign is_full   = (elem_count == dqs_pkg::CNT_W'(dqs_pkg::CAPACITY));
  assign is_empty  = (elem_count == '0);
  assign is_push   = (act == dqs_pkg::ACT_PUSH_FRONT) || (act == dqs_pkg::ACT_PUSH_BACK);
  assign store_val = dqs_pkg::to_store(data_in);

  // Address selection. Push front steps the pointer back one slot; push
  // back lands one past the last element. Reads serve pops at accept time
  // and the search walk afterwards.
  always_comb begin
    wr_en = accept && is_push && !is_full;
    if (act == dqs_pkg::ACT_PUSH_FRONT) begin
      wr_addr = dqs_pkg::ring_add(front, dqs_pkg::CNT_W'(dqs_pkg::CAPACITY - 1));
    end else begin
      wr_addr = dqs_pkg::ring_add(front, elem_count);
    end

    if (state == S_SCAN) begin
      rd_addr = dqs_pkg::ring_add(front, scan_idx);
    end else if (act == dqs_pkg::ACT_POP_BACK) begin
      rd_addr = dqs_pkg::ring_add(front, elem_count - dqs_pkg::CNT_W'(1));
    end else begin
      rd_addr = front;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      store[wr_addr] <= store_val;
    end
    rd_data <= store[rd_addr];
  end

  // Sequencer and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      front      <= '0;
      elem_count <= '0;
      cmp_vld    <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      // a taken result frees the output register, unless S_RESP refills it
      if (out_valid && !out_stall && (state != S_RESP)) begin
        out_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (accept) begin
            key        <= store_val;
            res_value  <= '0;
            res_found  <= 1'b0;
            res_status <= dqs_pkg::STAT_OK;
            scan_idx   <= '0;
            cmp_vld    <= 1'b0;
            state      <= S_RESP;
            case (act)
              dqs_pkg::ACT_PUSH_FRONT: begin
                if (is_full) begin
                  res_status <= dqs_pkg::STAT_FULL;
                end else begin
                  front      <= wr_addr;
                  elem_count <= elem_count + dqs_pkg::CNT_W'(1);
                end
              end
              dqs_pkg::ACT_PUSH_BACK: begin
                if (is_full) begin
                  res_status <= dqs_pkg::STAT_FULL;
                end else begin
                  elem_count <= elem_count + dqs_pkg::CNT_W'(1);
                end
              end
              dqs_pkg::ACT_POP_FRONT: begin
                if (is_empty) begin
                  res_status <= dqs_pkg::STAT_EMPTY;
                end else begin
                  front      <= dqs_pkg::ring_add(front, dqs_pkg::CNT_W'(1));
                  elem_count <= elem_count - dqs_pkg::CNT_W'(1);
                  state      <= S_POP;
                end
              end
              dqs_pkg::ACT_POP_BACK: begin
                if (is_empty) begin
                  res_status <= dqs_pkg::STAT_EMPTY;
                end else begin
                  elem_count <= elem_count - dqs_pkg::CNT_W'(1);
                  state      <= S_POP;
                end
              end
              dqs_pkg::ACT_SEARCH: begin
                if (!is_empty) begin
                  state <= S_SCAN;
                end
              end
              dqs_pkg::ACT_CLEAR: begin
                front      <= '0;
                elem_count <= '0;
              end
              default: begin
                // unused codes: nothing changes
              end
            endcase
          end
        end

        S_POP: begin
          res_value <= rd_data;
          state     <= S_RESP;
        end

        // One entry read per cycle; the compare acts on the read data in the cycle after the read.
        S_SCAN: begin
          if (cmp_vld && (rd_data == key)) begin
            res_found <= 1'b1;
            cmp_vld   <= 1'b0;
            state     <= S_RESP;
          end else if (cmp_vld && cmp_last) begin
            cmp_vld <= 1'b0;
            state   <= S_RESP;
          end else if (scan_idx != elem_count) begin
            cmp_vld  <= 1'b1;
            cmp_last <= (scan_idx == elem_count - dqs_pkg::CNT_W'(1));
            scan_idx <= scan_idx + dqs_pkg::CNT_W'(1);
          end else begin
            cmp_vld <= 1'b0;
          end
        end

        S_RESP: begin
          if (!out_valid || !out_stall) begin
            value_out <= dqs_pkg::to_out(res_value);
            found     <= res_found;
            status    <= res_status;
            count     <= dqs_pkg::to_count(elem_count);
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== rtl/dqs_checker.sv =====
// ----------------------------------------------------------------------------
// dqs_checker
// Port-level checks on the deque, bound to the top level.
// ----------------------------------------------------------------------------
`include "double_ended_queue_with_search_assert.svh"

module dqs_checker (
  input logic                               clk,
  input logic                               rst,
  input logic                               in_valid,
  input logic                               in_stall,
  input logic                               out_valid,
  input logic                               out_stall,
  input logic signed [dqs_pkg::DATA_W-1:0]  value_out,
  input logic                               found,
  input logic [dqs_pkg::STATUS_W-1:0]       status,
  input logic [dqs_pkg::COUNT_W-1:0]        count
);

  // an accepted request must raise in_stall before any further request is taken
  `DQS_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall, "request taken while busy")

  `DQS_ASSERT_NOW(a_found_only_ok, out_valid && found, status == dqs_pkg::STAT_OK, "found with error status")

  `DQS_ASSERT_NOW(a_value_zero_on_error, out_valid && (status != dqs_pkg::STAT_OK), value_out == '0, "value on failed request")

  `DQS_ASSERT_NOW(a_count_bound, out_valid, 32'(count) <= dqs_pkg::CAPACITY, "count beyond capacity")

  `DQS_ASSERT_NEXT(a_result_held, out_valid && out_stall, out_valid && $stable(value_out) && $stable(count), "stalled result changed")

endmodule

bind double_ended_queue_with_search dqs_checker u_dqs_checker (.*);
